>>> rtl/kpt_pkg.sv
// Shared constants, codes and types for the Kalman position tracker.
package kpt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int AXES_DEF      = 3;
    localparam int DATA_W        = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DT_W       = 17;
    localparam int VAR_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_VARIANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_VAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_VAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ACC_VAR  = 3'd5;

    localparam logic [DT_W-1:0]  RST_TIME_STEP     = 17'd328;
    localparam logic [VAR_W-1:0] RST_MEAS_VARIANCE = 31'd164;
    localparam logic [VAR_W-1:0] RST_PROCESS_NOISE = 31'd0;
    localparam logic [VAR_W-1:0] RST_INIT_POS_VAR  = 31'd16384;
    localparam logic [VAR_W-1:0] RST_INIT_VEL_VAR  = 31'd589824;
    localparam logic [VAR_W-1:0] RST_INIT_ACC_VAR  = 31'd65536;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_MEAS    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic sub;
    } t_alu_ctl;

endpackage

>>> rtl/kpt_mem.sv
// Working store: one write port, two registered read ports.
module kpt_mem
    import kpt_pkg::*;
#(
    parameter int DEPTH = 231,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr0,
    input  logic [AW-1:0]     i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd0;
    logic [DATA_W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

>>> rtl/kpt_alu.sv
// Shared fixed-point multiply, round, saturate and accumulate unit.
module kpt_alu
    import kpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_alu_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_op_a,
    input  logic signed [DATA_W-1:0] i_op_b,
    output logic signed [DATA_W-1:0] o_sum,
    output logic                     o_sat
);

    localparam logic signed [2*DATA_W-1:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [2*DATA_W-1:0] MAXV = 64'sd2147483647;
    localparam logic signed [2*DATA_W-1:0] MINV = -64'sd2147483648;

    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [DATA_W-1:0]   r_acc;
    logic signed [2*DATA_W-1:0] shifted;
    logic signed [DATA_W-1:0]   mres;
    logic                       msat;
    logic signed [DATA_W-1:0]   base;
    logic signed [DATA_W:0]     s;
    logic                       asat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_en) begin
            r_acc <= o_sum;
        end
    end

    always_comb begin
        shifted = (r_prod + RND) >>> FRAC_BITS;
        msat    = 1'b0;
        if (shifted > MAXV) begin
            mres = 32'sh7FFFFFFF;
            msat = 1'b1;
        end else if (shifted < MINV) begin
            mres = 32'sh80000000;
            msat = 1'b1;
        end else begin
            mres = shifted[DATA_W-1:0];
        end
        base = i_ctl.first ? '0 : r_acc;
        s = i_ctl.sub ? ({base[DATA_W-1], base} - {mres[DATA_W-1], mres})
                      : ({base[DATA_W-1], base} + {mres[DATA_W-1], mres});
        asat = s[DATA_W] != s[DATA_W-1];
        if (asat) begin
            o_sum = s[DATA_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            o_sum = s[DATA_W-1:0];
        end
        o_sat = msat | asat;
    end

endmodule

>>> rtl/kpt_div.sv
// Bit-serial restoring divider for Q-format a/b, truncating, saturating.
module kpt_div
    import kpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot,
    output logic                     o_sat
);

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] POS_LIM = NW'(64'h7FFFFFFF);
    localparam logic [NW-1:0] NEG_LIM = NW'(64'h80000000);

    logic              r_busy;
    logic              r_done;
    logic [NW-1:0]     r_num;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic              r_spec;
    logic              r_zero;
    logic [DATA_W-1:0] abs_num;
    logic [DATA_W-1:0] abs_den;
    logic [DATA_W:0]   trial;
    logic              ge;
    logic [NW-1:0]     neg_mag;

    assign abs_num = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign abs_den = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;
    assign trial   = {r_rem, r_num[NW-1]};
    assign ge      = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_spec <= i_den == '0;
                r_zero <= i_num == '0;
                r_neg  <= (i_den == '0) ? i_num[DATA_W-1]
                                        : (i_num[DATA_W-1] ^ i_den[DATA_W-1]);
                r_num  <= {abs_num, {FRAC_BITS{1'b0}}};
                r_den  <= abs_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? DATA_W'(trial - {1'b0, r_den}) : trial[DATA_W-1:0];
                r_num <= {r_num[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        neg_mag = ~r_num + 1'b1;
        o_sat   = 1'b0;
        if (r_spec) begin
            o_sat  = !r_zero;
            o_quot = r_zero ? '0 : (r_neg ? 32'sh80000000 : 32'sh7FFFFFFF);
        end else if (r_neg) begin
            if (r_num > NEG_LIM) begin
                o_quot = 32'sh80000000;
                o_sat  = 1'b1;
            end else begin
                o_quot = neg_mag[DATA_W-1:0];
            end
        end else begin
            if (r_num > POS_LIM) begin
                o_quot = 32'sh7FFFFFFF;
                o_sat  = 1'b1;
            end else begin
                o_quot = r_num[DATA_W-1:0];
            end
        end
    end

    assign o_done = r_done;

endmodule

>>> rtl/kalman_position_tracker.sv
// Constant-acceleration Kalman tracker: sequencer around a shared MAC unit.
// A tick runs MAC steps to predict state and covariance; a measurement runs MAC steps and
// pivoting plus 2*AXES divides per pivot column.
// Words are taken one at a time; each MAC step passes through the issue, multiply and
// accumulate states of the shared multiplier.
// Reset: synchronous; a clearing pass loads covariance and estimate before the input side
// is ready. A restart word runs the same pass.
module kalman_position_tracker
    import kpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int AXES      = AXES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [95:0]           i_s_tdata,  // meas_x, meas_y, meas_z
    input  logic [1:0]            i_s_tuser,  // command
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [95:0]           o_m_tdata,  // pos_x, pos_y, pos_z
    output logic [1:0]            o_m_tuser   // kind, saturated
);

    localparam int NS    = 3 * AXES;
    localparam int A2    = 2 * AXES;
    localparam int NNS   = NS * NS;
    localparam int P_B   = 0;
    localparam int T_B   = NNS;
    localparam int K_B   = 2 * NNS;
    localparam int M_B   = K_B + NS * AXES;
    localparam int X_B   = M_B + A2 * AXES;
    localparam int XN_B  = X_B + NS;
    localparam int Y_B   = XN_B + NS;
    localparam int FV_B  = Y_B + AXES;
    localparam int DEPTH = FV_B + AXES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NS + 1);
    localparam logic signed [DATA_W-1:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_ISSUE    = 4'd2;
    localparam logic [3:0] ST_MUL      = 4'd3;
    localparam logic [3:0] ST_ACC      = 4'd4;
    localparam logic [3:0] ST_PIV_RD   = 4'd5;
    localparam logic [3:0] ST_PIV_CMP  = 4'd6;
    localparam logic [3:0] ST_SW_RD    = 4'd7;
    localparam logic [3:0] ST_SW_W0    = 4'd8;
    localparam logic [3:0] ST_SW_W1    = 4'd9;
    localparam logic [3:0] ST_DIVP_RD  = 4'd10;
    localparam logic [3:0] ST_DIVP_LAT = 4'd11;
    localparam logic [3:0] ST_DIV_RD   = 4'd12;
    localparam logic [3:0] ST_DIV_GO   = 4'd13;
    localparam logic [3:0] ST_DIV_WAIT = 4'd14;
    localparam logic [3:0] ST_EMIT     = 4'd15;

    localparam logic [4:0] OP_HDT1 = 5'd0;
    localparam logic [4:0] OP_HDT2 = 5'd1;
    localparam logic [4:0] OP_XN   = 5'd2;
    localparam logic [4:0] OP_XCPY = 5'd3;
    localparam logic [4:0] OP_FP   = 5'd4;
    localparam logic [4:0] OP_FPF  = 5'd5;
    localparam logic [4:0] OP_Q    = 5'd6;
    localparam logic [4:0] OP_Y    = 5'd7;
    localparam logic [4:0] OP_S    = 5'd8;
    localparam logic [4:0] OP_SI   = 5'd9;
    localparam logic [4:0] OP_FV   = 5'd10;
    localparam logic [4:0] OP_ELIM = 5'd11;
    localparam logic [4:0] OP_K    = 5'd12;
    localparam logic [4:0] OP_DX   = 5'd13;
    localparam logic [4:0] OP_XADD = 5'd14;
    localparam logic [4:0] OP_KHP  = 5'd15;
    localparam logic [4:0] OP_PSUB = 5'd16;
    localparam logic [4:0] OP_SEED = 5'd17;

    // configuration
    logic [DT_W-1:0]  r_dt;
    logic [VAR_W-1:0] r_r;
    logic [VAR_W-1:0] r_q;
    logic [VAR_W-1:0] r_ipv;
    logic [VAR_W-1:0] r_ivv;
    logic [VAR_W-1:0] r_iav;

    // sequencer
    logic [3:0]               r_state;
    logic [4:0]               r_op;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            r_j;
    logic [IW-1:0]            r_k;
    logic [IW-1:0]            r_c;
    logic [IW-1:0]            r_pr;
    logic [DATA_W:0]          r_best;
    logic signed [DATA_W-1:0] r_piv;
    logic signed [DATA_W-1:0] r_hdt;
    logic                     r_boot;
    logic                     r_init;
    logic                     r_sat;
    logic                     r_kind;
    logic signed [DATA_W-1:0] r_z   [AXES];
    logic signed [DATA_W-1:0] r_pos [AXES];

    // result word
    logic                     r_ov;
    logic                     r_out_kind;
    logic                     r_out_sat;
    logic [95:0]              r_out_data;

    // decoded MAC step
    int                       d_n, d_m, d_p, d_ra0, d_ra1, d_dst;
    logic                     d_amem, d_bmem, d_sub, d_dmem;
    logic signed [DATA_W-1:0] d_aval, d_bval;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [AW-1:0]            mem_ra0;
    logic [AW-1:0]            mem_ra1;
    logic [DATA_W-1:0]        rd0;
    logic [DATA_W-1:0]        rd1;

    t_alu_ctl                 alu_ctl;
    logic signed [DATA_W-1:0] alu_a, alu_b, alu_sum;
    logic                     alu_sat;
    logic                     div_done, div_sat;
    logic signed [DATA_W-1:0] div_q;

    logic                     last_k, last_j, last_i;
    logic [DATA_W:0]          piv_abs;
    logic                     piv_take;
    logic [DATA_W:0]          piv_best;
    logic [IW-1:0]            piv_row;
    logic [DATA_W-1:0]        clr_val;
    int                       clr_addr;
    logic                     s_acc;

    function automatic logic signed [DATA_W-1:0] f_ent(
        input int r, input int c,
        input logic signed [DATA_W-1:0] dt, input logic signed [DATA_W-1:0] hdt
    );
        logic signed [DATA_W-1:0] v;
        v = '0;
        if (r == c) v = ONE;
        else if (r < AXES && c == r + AXES) v = dt;
        else if (r < AXES && c == r + A2) v = hdt;
        else if (r >= AXES && r < A2 && c == r + AXES) v = dt;
        return v;
    endfunction

    function automatic int m_addr(input int r, input int c);
        return M_B + r * A2 + c;
    endfunction

    function automatic logic signed [DATA_W-1:0] z_sel(input int a,
        input logic signed [DATA_W-1:0] z0, input logic signed [DATA_W-1:0] z1,
        input logic signed [DATA_W-1:0] z2);
        logic signed [DATA_W-1:0] v;
        v = '0;
        if (a == 0) v = z0;
        else if (a == 1) v = z1;
        else if (a == 2) v = z2;
        return v;
    endfunction

    logic signed [DATA_W-1:0] z_w [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            z_w[a] = (a < AXES) ? r_z[(a < AXES) ? a : 0] : '0;
        end
    end

    // step decoder
    always_comb begin
        int ii, jj, kk, cc;
        logic signed [DATA_W-1:0] dt_s;
        ii = int'(r_i);
        jj = int'(r_j);
        kk = int'(r_k);
        cc = int'(r_c);
        dt_s   = {{(DATA_W-DT_W){1'b0}}, r_dt};
        d_n    = 1;
        d_m    = 1;
        d_p    = 1;
        d_amem = 1'b0;
        d_aval = ONE;
        d_bmem = 1'b0;
        d_bval = '0;
        d_ra0  = 0;
        d_ra1  = 0;
        d_sub  = 1'b0;
        d_dmem = 1'b1;
        d_dst  = 0;
        unique case (r_op)
            OP_HDT1: begin
                d_aval = dt_s; d_bval = dt_s; d_dmem = 1'b0;
            end
            OP_HDT2: begin
                d_aval = r_hdt; d_bval = HALF; d_dmem = 1'b0;
            end
            OP_XN: begin
                d_n = NS; d_m = NS;
                d_aval = f_ent(ii, kk, dt_s, r_hdt);
                d_bmem = 1'b1; d_ra1 = X_B + kk; d_dst = XN_B + ii;
            end
            OP_XCPY: begin
                d_n = NS; d_bmem = 1'b1; d_ra1 = XN_B + ii; d_dst = X_B + ii;
            end
            OP_FP: begin
                d_n = NS; d_m = NS; d_p = NS;
                d_aval = f_ent(ii, kk, dt_s, r_hdt);
                d_bmem = 1'b1; d_ra1 = P_B + kk * NS + jj; d_dst = T_B + ii * NS + jj;
            end
            OP_FPF: begin
                d_n = NS; d_m = NS; d_p = NS;
                d_amem = 1'b1; d_ra0 = T_B + ii * NS + kk;
                d_bval = f_ent(jj, kk, dt_s, r_hdt); d_dst = P_B + ii * NS + jj;
            end
            OP_Q: begin
                d_n = NS; d_m = 2;
                d_bmem = (kk == 0); d_ra1 = P_B + ii * NS + ii;
                d_bval = {1'b0, r_q}; d_dst = P_B + ii * NS + ii;
            end
            OP_Y: begin
                d_n = AXES; d_m = 2; d_sub = 1'b1;
                d_bmem = (kk != 0); d_ra1 = X_B + ii;
                d_bval = z_sel(ii, z_w[0], z_w[1], z_w[2]); d_dst = Y_B + ii;
            end
            OP_S: begin
                d_n = AXES; d_m = 2; d_p = AXES;
                d_bmem = (kk == 0); d_ra1 = P_B + ii * NS + jj;
                d_bval = (ii == jj) ? {1'b0, r_r} : '0; d_dst = m_addr(ii, jj);
            end
            OP_SI: begin
                d_n = AXES; d_p = AXES;
                d_bval = (ii == jj) ? ONE : '0; d_dst = m_addr(ii, AXES + jj);
            end
            OP_FV: begin
                d_n = AXES; d_bmem = 1'b1; d_ra1 = m_addr(ii, cc); d_dst = FV_B + ii;
            end
            OP_ELIM: begin
                // the pivot row subtracts a zero operand and is rewritten unchanged
                d_n = AXES; d_m = 2; d_p = A2; d_sub = 1'b1;
                d_amem = (kk != 0); d_ra0 = FV_B + ii;
                d_bmem = (kk == 0) || (ii != cc);
                d_ra1  = (kk == 0) ? m_addr(ii, jj) : m_addr(cc, jj);
                d_dst  = m_addr(ii, jj);
            end
            OP_K: begin
                d_n = NS; d_m = AXES; d_p = AXES;
                d_amem = 1'b1; d_ra0 = P_B + ii * NS + kk;
                d_bmem = 1'b1; d_ra1 = m_addr(kk, AXES + jj); d_dst = K_B + ii * AXES + jj;
            end
            OP_DX: begin
                d_n = NS; d_m = AXES;
                d_amem = 1'b1; d_ra0 = K_B + ii * AXES + kk;
                d_bmem = 1'b1; d_ra1 = Y_B + kk; d_dst = XN_B + ii;
            end
            OP_XADD: begin
                d_n = NS; d_m = 2;
                d_bmem = 1'b1; d_ra1 = (kk == 0) ? X_B + ii : XN_B + ii; d_dst = X_B + ii;
            end
            OP_KHP: begin
                d_n = NS; d_m = AXES; d_p = NS;
                d_amem = 1'b1; d_ra0 = K_B + ii * AXES + kk;
                d_bmem = 1'b1; d_ra1 = P_B + kk * NS + jj; d_dst = T_B + ii * NS + jj;
            end
            OP_PSUB: begin
                d_n = NS; d_m = 2; d_p = NS; d_sub = 1'b1;
                d_bmem = 1'b1;
                d_ra1 = (kk == 0) ? P_B + ii * NS + jj : T_B + ii * NS + jj;
                d_dst = P_B + ii * NS + jj;
            end
            OP_SEED: begin
                d_n = NS;
                d_bval = (ii < AXES) ? z_sel(ii, z_w[0], z_w[1], z_w[2]) : '0;
                d_dst = X_B + ii;
            end
            default: ;
        endcase
    end

    // clearing pass source
    always_comb begin
        logic [VAR_W-1:0] v;
        int ii;
        ii = int'(r_i);
        if (ii < AXES)    v = r_boot ? RST_INIT_POS_VAR : r_ipv;
        else if (ii < A2) v = r_boot ? RST_INIT_VEL_VAR : r_ivv;
        else              v = r_boot ? RST_INIT_ACC_VAR : r_iav;
        if (ii < NS) begin
            clr_addr = P_B + ii * NS + int'(r_j);
            clr_val  = (r_i == r_j) ? {1'b0, v} : '0;
        end else begin
            clr_addr = X_B + int'(r_j);
            clr_val  = '0;
        end
    end

    assign last_k = int'(r_k) == d_m - 1;
    assign last_j = int'(r_j) == d_p - 1;
    assign last_i = int'(r_i) == d_n - 1;

    assign alu_ctl.mul_en = r_state == ST_MUL;
    assign alu_ctl.acc_en = r_state == ST_ACC;
    assign alu_ctl.first  = r_k == '0;
    assign alu_ctl.sub    = d_sub && (r_k != '0);
    assign alu_a = d_amem ? signed'(rd0) : d_aval;
    assign alu_b = d_bmem ? signed'(rd1) : d_bval;

    // pivot search compare
    assign piv_abs  = rd0[DATA_W-1] ? (~{1'b1, rd0} + 1'b1) : {1'b0, rd0};
    assign piv_take = (r_i == r_c) || (piv_abs > r_best);
    assign piv_best = piv_take ? piv_abs : r_best;
    assign piv_row  = piv_take ? r_i : r_pr;

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(d_dst);
        mem_wdata = alu_sum;
        mem_ra0   = AW'(d_ra0);
        mem_ra1   = AW'(d_ra1);
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(clr_addr);
                mem_wdata = clr_val;
            end
            ST_ACC: begin
                mem_we = last_k && d_dmem;
            end
            ST_PIV_RD: begin
                mem_ra0 = AW'(m_addr(int'(r_i), int'(r_c)));
            end
            ST_SW_RD, ST_SW_W0, ST_SW_W1: begin
                mem_ra0 = AW'(m_addr(int'(r_c), int'(r_j)));
                mem_ra1 = AW'(m_addr(int'(r_pr), int'(r_j)));
                if (r_state == ST_SW_W0) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(m_addr(int'(r_c), int'(r_j)));
                    mem_wdata = rd1;
                end else if (r_state == ST_SW_W1) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(m_addr(int'(r_pr), int'(r_j)));
                    mem_wdata = rd0;
                end
            end
            ST_DIVP_RD: begin
                mem_ra0 = AW'(m_addr(int'(r_c), int'(r_c)));
            end
            ST_DIV_RD: begin
                mem_ra0 = AW'(m_addr(int'(r_c), int'(r_j)));
            end
            ST_DIV_WAIT: begin
                mem_we    = div_done;
                mem_waddr = AW'(m_addr(int'(r_c), int'(r_j)));
                mem_wdata = div_q;
            end
            default: ;
        endcase
    end

    assign s_acc = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= RST_TIME_STEP;
            r_r     <= RST_MEAS_VARIANCE;
            r_q     <= RST_PROCESS_NOISE;
            r_ipv   <= RST_INIT_POS_VAR;
            r_ivv   <= RST_INIT_VEL_VAR;
            r_iav   <= RST_INIT_ACC_VAR;
            r_state <= ST_CLEAR;
            r_op    <= OP_HDT1;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_c     <= '0;
            r_boot  <= 1'b1;
            r_init  <= 1'b0;
            r_sat   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TIME_STEP:     r_dt  <= i_cfg_wdata[DT_W-1:0];
                    REG_MEAS_VARIANCE: r_r   <= i_cfg_wdata;
                    REG_PROCESS_NOISE: r_q   <= i_cfg_wdata;
                    REG_INIT_POS_VAR:  r_ipv <= i_cfg_wdata;
                    REG_INIT_VEL_VAR:  r_ivv <= i_cfg_wdata;
                    REG_INIT_ACC_VAR:  r_iav <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // the emit state refills the output register itself
            if (o_m_tvalid && i_m_tready && r_state != ST_EMIT) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    if (r_j == IW'(NS - 1)) begin
                        r_j <= '0;
                        if (r_i == IW'(NS)) begin
                            r_state <= ST_IDLE;
                            r_boot  <= 1'b0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        r_sat <= 1'b0;
                        for (int a = 0; a < AXES; a++) begin
                            r_z[a] <= i_s_tdata[a*DATA_W +: DATA_W];
                        end
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                        unique case (i_s_tuser)
                            CMD_RESTART: begin
                                r_init  <= 1'b0;
                                r_state <= ST_CLEAR;
                            end
                            CMD_TICK: begin
                                if (r_init) begin
                                    r_kind  <= KIND_TICK;
                                    r_op    <= OP_HDT1;
                                    r_state <= ST_ISSUE;
                                end
                            end
                            CMD_MEAS: begin
                                r_kind  <= KIND_MEAS;
                                r_op    <= OP_Y;
                                r_state <= ST_ISSUE;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ISSUE: r_state <= ST_MUL;
                ST_MUL:   r_state <= ST_ACC;
                ST_ACC: begin
                    r_sat <= r_sat | alu_sat;
                    if (!last_k) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_ISSUE;
                    end else begin
                        r_k <= '0;
                        if (!d_dmem) begin
                            r_hdt <= alu_sum;
                        end
                        if (!last_j) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_ISSUE;
                        end else begin
                            r_j <= '0;
                            if (!last_i) begin
                                r_i     <= r_i + 1'b1;
                                r_state <= ST_ISSUE;
                            end else begin
                                // next pivot column restarts its search at the diagonal
                                r_i <= (r_op == OP_ELIM && r_c != IW'(AXES - 1))
                                       ? r_c + 1'b1 : '0;
                                unique case (r_op)
                                    OP_HDT1: begin r_op <= OP_HDT2; r_state <= ST_ISSUE; end
                                    OP_HDT2: begin r_op <= OP_XN;   r_state <= ST_ISSUE; end
                                    OP_XN:   begin r_op <= OP_XCPY; r_state <= ST_ISSUE; end
                                    OP_XCPY: begin r_op <= OP_FP;   r_state <= ST_ISSUE; end
                                    OP_FP:   begin r_op <= OP_FPF;  r_state <= ST_ISSUE; end
                                    OP_FPF:  begin r_op <= OP_Q;    r_state <= ST_ISSUE; end
                                    OP_Y:    begin r_op <= OP_S;    r_state <= ST_ISSUE; end
                                    OP_S:    begin r_op <= OP_SI;   r_state <= ST_ISSUE; end
                                    OP_SI: begin
                                        r_c     <= '0;
                                        r_state <= ST_PIV_RD;
                                    end
                                    OP_FV:   begin r_op <= OP_ELIM; r_state <= ST_ISSUE; end
                                    OP_ELIM: begin
                                        if (r_c == IW'(AXES - 1)) begin
                                            r_op    <= OP_K;
                                            r_state <= ST_ISSUE;
                                        end else begin
                                            r_c     <= r_c + 1'b1;
                                            r_state <= ST_PIV_RD;
                                        end
                                    end
                                    OP_K:    begin r_op <= OP_DX;   r_state <= ST_ISSUE; end
                                    OP_DX:   begin r_op <= OP_XADD; r_state <= ST_ISSUE; end
                                    OP_XADD: begin r_op <= OP_KHP;  r_state <= ST_ISSUE; end
                                    OP_KHP:  begin r_op <= OP_PSUB; r_state <= ST_ISSUE; end
                                    OP_PSUB: begin
                                        if (r_init) begin
                                            r_state <= ST_EMIT;
                                        end else begin
                                            r_op    <= OP_SEED;
                                            r_state <= ST_ISSUE;
                                        end
                                    end
                                    OP_SEED: begin
                                        r_init  <= 1'b1;
                                        r_state <= ST_EMIT;
                                    end
                                    default: r_state <= ST_EMIT;
                                endcase
                            end
                        end
                    end
                end
                ST_PIV_RD: r_state <= ST_PIV_CMP;
                ST_PIV_CMP: begin
                    r_best <= piv_best;
                    r_pr   <= piv_row;
                    if (r_i == IW'(AXES - 1)) begin
                        r_j <= '0;
                        if (piv_best == '0) begin
                            // singular innovation matrix: no gain this time
                            r_sat <= 1'b1;
                            r_i   <= '0;
                            r_k   <= '0;
                            if (r_init) begin
                                r_state <= ST_EMIT;
                            end else begin
                                r_op    <= OP_SEED;
                                r_state <= ST_ISSUE;
                            end
                        end else if (piv_row != r_c) begin
                            r_state <= ST_SW_RD;
                        end else begin
                            r_state <= ST_DIVP_RD;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_PIV_RD;
                    end
                end
                ST_SW_RD: r_state <= ST_SW_W0;
                ST_SW_W0: r_state <= ST_SW_W1;
                ST_SW_W1: begin
                    if (r_j == IW'(A2 - 1)) begin
                        r_j     <= '0;
                        r_state <= ST_DIVP_RD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_SW_RD;
                    end
                end
                ST_DIVP_RD: r_state <= ST_DIVP_LAT;
                ST_DIVP_LAT: begin
                    r_piv   <= rd0;
                    r_j     <= '0;
                    r_state <= ST_DIV_RD;
                end
                ST_DIV_RD: r_state <= ST_DIV_GO;
                ST_DIV_GO: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_sat <= r_sat | div_sat;
                        if (r_j == IW'(A2 - 1)) begin
                            r_j     <= '0;
                            r_i     <= '0;
                            r_k     <= '0;
                            r_op    <= OP_FV;
                            r_state <= ST_ISSUE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_DIV_RD;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov       <= 1'b1;
                        r_out_kind <= r_kind;
                        r_out_sat  <= r_sat;
                        for (int a = 0; a < 3; a++) begin
                            r_out_data[a*DATA_W +: DATA_W] <=
                                (a < AXES) ? r_pos[(a < AXES) ? a : 0] : '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // position mirror of the estimate, fed from the write port
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            if (mem_we && mem_waddr == AW'(X_B + a)) begin
                r_pos[a] <= mem_wdata;
            end
        end
    end

    kpt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_ra0),
        .i_raddr1 (mem_ra1),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    kpt_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk  (i_clk),
        .i_ctl  (alu_ctl),
        .i_op_a (alu_a),
        .i_op_b (alu_b),
        .o_sum  (alu_sum),
        .o_sat  (alu_sat)
    );

    kpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIV_GO),
        .i_num   (rd0),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_sat   (div_sat)
    );

    assign o_s_tready = r_state == ST_IDLE;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = {r_out_sat, r_out_kind};

endmodule

>>> tb/kalman_position_tracker_test.sv
// Testbench for the Kalman position tracker: directed and random words against a predictor.
module kalman_position_tracker_test;
    import kpt_pkg::*;

    localparam int NS = 9;
    localparam int AX = 3;
    localparam int ONE = 65536;
    localparam int SETTLE = 6000;          // longer than one tick of the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic       kind;
        logic [31:0] pos [3];
        logic       sat;
    } t_estimate;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    kalman_position_tracker DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [16:0] dt_reg;
    logic [30:0] rvar_reg, qvar_reg, pvar_reg, vvar_reg, avar_reg;
    int  est [NS];
    int  cov [NS*NS];
    bit  seeded;
    bit  sat_hit;

    t_estimate pending [$];
    int errors = 0;
    int n_words = 0, n_ticks = 0, n_meas = 0, n_sat = 0;
    bit stall_quiet = 1'b0;

    function automatic int clamp(longint v);
        if (v > 64'sd2147483647) begin sat_hit = 1; return 32'h7FFFFFFF; end
        if (v < -64'sd2147483648) begin sat_hit = 1; return 32'h80000000; end
        return int'(v);
    endfunction

    function automatic int qadd(int a, int b);
        return clamp(longint'(a) + longint'(b));
    endfunction

    function automatic int qsub(int a, int b);
        return clamp(longint'(a) - longint'(b));
    endfunction

    function automatic int qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp(p >>> 16);
    endfunction

    function automatic int qdiv(int a, int b);
        if (b == 0) begin
            if (a == 0) return 0;
            sat_hit = 1;
            return a > 0 ? 32'h7FFFFFFF : 32'h80000000;
        end
        return clamp((longint'(a) * 64'sd65536) / longint'(b));
    endfunction

    // c = a (n x m) times b (m x p), or times b' with b stored p x m
    function automatic void matmul(input int a [NS*NS], input int b [NS*NS],
                                   output int c [NS*NS], input int n, m, p, bit tr);
        int acc;
        int bv;
        c = '{default: 0};
        for (int i = 0; i < n; i++)
            for (int j = 0; j < p; j++) begin
                acc = 0;
                for (int k = 0; k < m; k++) begin
                    bv = tr ? b[j*m+k] : b[k*p+j];
                    acc = qadd(acc, qmul(a[i*m+k], bv));
                end
                c[i*p+j] = acc;
            end
    endfunction

    function automatic void clear_filter();
        est = '{default: 0};
        cov = '{default: 0};
        for (int i = 0; i < NS; i++)
            cov[i*NS+i] = int'({1'b0, i < AX ? pvar_reg : (i < 2*AX ? vvar_reg : avar_reg)});
        seeded = 0;
    endfunction

    function automatic void propagate();
        int fm [NS*NS];
        int tmp [NS*NS];
        int xv [NS*NS];
        int xn [NS*NS];
        int dt;
        int hdt;
        dt = int'({15'd0, dt_reg});
        hdt = qmul(qmul(dt, dt), ONE / 2);
        fm = '{default: 0};
        for (int i = 0; i < NS; i++) fm[i*NS+i] = ONE;
        for (int a = 0; a < AX; a++) begin
            fm[a*NS+AX+a] = dt;
            fm[a*NS+2*AX+a] = hdt;
            fm[(AX+a)*NS+2*AX+a] = dt;
        end
        xv = '{default: 0};
        for (int i = 0; i < NS; i++) xv[i] = est[i];
        matmul(fm, xv, xn, NS, NS, 1, 0);
        for (int i = 0; i < NS; i++) est[i] = xn[i];
        matmul(fm, cov, tmp, NS, NS, NS, 0);
        matmul(tmp, fm, cov, NS, NS, NS, 1);
        for (int i = 0; i < NS; i++)
            cov[i*NS+i] = qadd(cov[i*NS+i], int'({1'b0, qvar_reg}));
    endfunction

    // Gauss-Jordan with partial pivoting on the 3x3 innovation covariance
    function automatic bit invert3(input int s [NS*NS], output int inv [NS*NS]);
        int m [AX][2*AX];
        int pr, piv, f, t;
        longint best, v;
        inv = '{default: 0};
        for (int r = 0; r < AX; r++)
            for (int j = 0; j < AX; j++) begin
                m[r][j] = s[r*AX+j];
                m[r][AX+j] = (r == j) ? ONE : 0;
            end
        for (int c = 0; c < AX; c++) begin
            pr = c;
            best = -1;
            for (int r = c; r < AX; r++) begin
                v = m[r][c] < 0 ? -longint'(m[r][c]) : longint'(m[r][c]);
                if (v > best) begin best = v; pr = r; end
            end
            if (best == 0) return 0;
            if (pr != c)
                for (int j = 0; j < 2*AX; j++) begin
                    t = m[c][j]; m[c][j] = m[pr][j]; m[pr][j] = t;
                end
            piv = m[c][c];
            for (int j = 0; j < 2*AX; j++) m[c][j] = qdiv(m[c][j], piv);
            for (int r = 0; r < AX; r++) begin
                if (r == c) continue;
                f = m[r][c];
                for (int j = 0; j < 2*AX; j++) m[r][j] = qsub(m[r][j], qmul(f, m[c][j]));
            end
        end
        for (int r = 0; r < AX; r++)
            for (int j = 0; j < AX; j++) inv[r*AX+j] = m[r][AX+j];
        return 1;
    endfunction

    function automatic void correct(int z [AX]);
        int y [NS*NS];
        int s [NS*NS];
        int sinv [NS*NS];
        int pht [NS*NS];
        int gain [NS*NS];
        int dx [NS*NS];
        int khp [NS*NS];
        y = '{default: 0};
        s = '{default: 0};
        pht = '{default: 0};
        for (int a = 0; a < AX; a++) y[a] = qsub(z[a], est[a]);
        for (int i = 0; i < AX; i++)
            for (int j = 0; j < AX; j++) begin
                s[i*AX+j] = cov[i*NS+j];
                if (i == j) s[i*AX+j] = qadd(s[i*AX+j], int'({1'b0, rvar_reg}));
            end
        if (invert3(s, sinv)) begin
            for (int r = 0; r < NS; r++)
                for (int j = 0; j < AX; j++) pht[r*AX+j] = cov[r*NS+j];
            matmul(pht, sinv, gain, NS, AX, AX, 0);
            matmul(gain, y, dx, NS, AX, 1, 0);
            for (int r = 0; r < NS; r++) est[r] = qadd(est[r], dx[r]);
            matmul(gain, cov, khp, NS, AX, NS, 0);
            for (int i = 0; i < NS*NS; i++) cov[i] = qsub(cov[i], khp[i]);
        end else begin
            sat_hit = 1;
        end
        if (!seeded) begin
            est = '{default: 0};
            for (int a = 0; a < AX; a++) est[a] = z[a];
            seeded = 1;
        end
    endfunction

    // advances the predictor by one word; queues the expected estimate if one is due
    function automatic void track_word(logic [1:0] cmd, logic [95:0] data);
        t_estimate e;
        int z [AX];
        sat_hit = 0;
        case (cmd)
            CMD_RESTART: begin clear_filter(); return; end
            CMD_TICK: begin
                if (!seeded) return;
                propagate();
            end
            CMD_MEAS: begin
                for (int a = 0; a < AX; a++) z[a] = int'(data[32*a +: 32]);
                correct(z);
            end
            default: return;
        endcase
        e.kind = (cmd == CMD_MEAS) ? KIND_MEAS : KIND_TICK;
        for (int a = 0; a < 3; a++) e.pos[a] = est[a];
        e.sat = sat_hit;
        pending.push_back(e);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // receiver stalls
    always @(negedge i_clk) begin
        if (stall_quiet || !i_rst_n) i_m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 8) i_m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 30) i_m_tready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        t_estimate e;
        bit bad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: tdata=%h tuser=%b", o_m_tdata, o_m_tuser);
            end else begin
                e = pending.pop_front();
                bad = (o_m_tuser[0] !== e.kind) || (o_m_tuser[1] !== e.sat);
                for (int a = 0; a < 3; a++) bad |= (o_m_tdata[32*a +: 32] !== e.pos[a]);
                if (bad) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp kind=%b sat=%b pos=%h %h %h, got kind=%b sat=%b pos=%h %h %h",
                                 e.kind, e.sat, e.pos[0], e.pos[1], e.pos[2],
                                 o_m_tuser[0], o_m_tuser[1],
                                 o_m_tdata[31:0], o_m_tdata[63:32], o_m_tdata[95:64]);
                end
                if (e.kind == KIND_MEAS) n_meas++; else n_ticks++;
                if (e.sat) n_sat++;
            end
        end
    end

    // called at a falling edge; returns at a falling edge with the word accepted
    task automatic send_word(logic [1:0] cmd, int x, int y, int z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = cmd;
        i_s_tdata = {z, y, x};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_word(cmd, {z, y, x});
        n_words++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid = 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_TIME_STEP:     dt_reg = val[16:0];
            REG_MEAS_VARIANCE: rvar_reg = val;
            REG_PROCESS_NOISE: qvar_reg = val;
            REG_INIT_POS_VAR:  pvar_reg = val;
            REG_INIT_VEL_VAR:  vvar_reg = val;
            default:           avar_reg = val;
        endcase
    endtask

    task automatic set_all(logic [30:0] dt, rv, qv, pv, vv, av);
        settle();
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_MEAS_VARIANCE, rv);
        write_reg(REG_PROCESS_NOISE, qv);
        write_reg(REG_INIT_POS_VAR, pv);
        write_reg(REG_INIT_VEL_VAR, vv);
        write_reg(REG_INIT_ACC_VAR, av);
    endtask

    task automatic test_directed();
        send_word(CMD_TICK, 0, 0, 0);           // ignored before the first fix
        send_word(CMD_UNUSED, -1, -1, -1);
        send_word(CMD_MEAS, 32'h7FFFFFFF, 32'h80000000, 0);
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_MEAS, 32'h80000000, 32'h7FFFFFFF, -1);
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_RESTART, 0, 0, 0);
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_MEAS, ONE, 2 * ONE, -3 * ONE);
        for (int i = 0; i < 4; i++) send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_MEAS, ONE + 700, 2 * ONE - 300, -3 * ONE + 50);
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_MEAS, 0, 0, 0);
        send_word(CMD_UNUSED, 0, 0, 0);
    endtask

    task automatic test_singular_gain();
        // zero position variance and zero measurement noise leave S all zero
        set_all(328, 0, 0, 0, 589824, 65536);
        send_word(CMD_RESTART, 0, 0, 0);
        send_word(CMD_MEAS, 5 * ONE, -ONE, 77);
        send_word(CMD_MEAS, 6 * ONE, -ONE, 78);
        send_word(CMD_TICK, 0, 0, 0);
    endtask

    task automatic short_track(int len);
        for (int i = 0; i < len; i++)
            if (i % 3 == 0) send_word(CMD_MEAS, i * 4000, -i * 3000, i * 100);
            else send_word(CMD_TICK, 0, 0, 0);
    endtask

    task automatic test_config_extremes();
        set_all(65536, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_word(CMD_RESTART, 0, 0, 0);
        short_track(6);
        set_all(1, 1, 0, 1, 0, 0);
        send_word(CMD_RESTART, 0, 0, 0);
        short_track(6);
        set_all(0, 164, 655, 16384, 589824, 65536);   // zero step: F is identity
        send_word(CMD_RESTART, 0, 0, 0);
        short_track(6);
        set_all(31'h1FFFF, 31'h55555555, 31'h2AAAAAAA, 31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA);
        send_word(CMD_RESTART, 0, 0, 0);
        short_track(5);
    endtask

    task automatic test_random_tracks(int total);
        int px, py, pz, vx, vy, vz, r;
        px = 0; py = 0; pz = 0; vx = 100; vy = -50; vz = 20;
        for (int i = 0; i < total; i++) begin
            if (i % 60 == 59) begin
                set_all($urandom_range(1, 2000), $urandom_range(0, 40000), $urandom_range(0, 300),
                        $urandom_range(0, 200000), $urandom_range(0, 1000000),
                        $urandom_range(0, 200000));
                send_word(CMD_RESTART, 0, 0, 0);
            end
            stall_quiet = (i % 80) < 15;
            r = $urandom_range(0, 99);
            px += vx; py += vy; pz += vz;
            if (r < 55) send_word(CMD_TICK, 0, 0, 0);
            else if (r < 85)
                send_word(CMD_MEAS, px + int'($urandom_range(0, 2000)) - 1000,
                          py + int'($urandom_range(0, 2000)) - 1000,
                          pz + int'($urandom_range(0, 2000)) - 1000);
            else if (r < 92) send_word(CMD_MEAS, $urandom, $urandom, $urandom);
            else if (r < 96) send_word(CMD_RESTART, $urandom, $urandom, $urandom);
            else send_word(CMD_UNUSED, $urandom, $urandom, $urandom);
        end
        stall_quiet = 1'b0;
    endtask

    initial begin
        dt_reg = RST_TIME_STEP;
        rvar_reg = RST_MEAS_VARIANCE;
        qvar_reg = RST_PROCESS_NOISE;
        pvar_reg = RST_INIT_POS_VAR;
        vvar_reg = RST_INIT_VEL_VAR;
        avar_reg = RST_INIT_ACC_VAR;
        clear_filter();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_singular_gain();
        test_config_extremes();
        test_random_tracks(300);
        settle();
        $display("run covered %0d input words: %0d tick and %0d measurement estimates checked,",
                 n_words, n_ticks, n_meas);
        $display("%0d of them saturated, across register extremes, restarts and random stalls",
                 n_sat);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
